// File: rtl/core/sbp_pkg.sv
// ----------------------------------------------------------------------------
// sbp_pkg: shared types and constants for the sprite blitter
// Beat layouts, configuration register map and color-key codes.
// ----------------------------------------------------------------------------
package sbp_pkg;

	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int PIX_W      = 16;
	localparam int COORD_W    = 10;
	localparam int PAL_IDX_W  = 4;
	localparam int PAL_DEPTH  = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_USE_PALETTE = 3'd6;

	// request types
	localparam logic REQ_PIXEL   = 1'b0;
	localparam logic REQ_PAL_WR  = 1'b1;

	// color keys
	localparam logic [PIX_W-1:0] KEY_ZERO = 16'h0000;
	localparam logic [PIX_W-1:0] KEY_FULL = 16'h000F;

	typedef struct packed {
		logic                  req_type;
		logic [PIX_W-1:0]      pixel_value;
		logic [PAL_IDX_W-1:0]  palette_index;
	} item_t;

	typedef struct packed {
		logic                write_valid;
		logic [COORD_W-1:0]  dest_col;
		logic [COORD_W-1:0]  dest_row;
		logic [PIX_W-1:0]    dest_value;
		logic                sprite_done;
	} result_t;

	typedef struct packed {
		logic signed [CFG_W-1:0]  offset_x;
		logic signed [CFG_W-1:0]  offset_y;
		logic [CFG_W-1:0]         src_width;
		logic [CFG_W-1:0]         src_height;
		logic [CFG_W-1:0]         dest_width;
		logic [CFG_W-1:0]         dest_height;
		logic                     use_palette;
	} cfg_t;

	// classified beat between front and back
	typedef struct packed {
		logic                  pal_wr;   // palette entry write
		logic                  wr;       // pixel lands: inside and opaque
		logic                  lut;      // value goes through the palette
		logic [COORD_W-1:0]    col;
		logic [COORD_W-1:0]    row;
		logic [PIX_W-1:0]      value;
		logic [PAL_IDX_W-1:0]  idx;
		logic                  done;
	} mid_t;

endpackage

// File: rtl/core/sbp_fifo.sv
// ----------------------------------------------------------------------------
// sbp_fifo: small synchronous queue
// Register-based queue with count; push and pop may happen in one cycle.
// ----------------------------------------------------------------------------
module sbp_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [W-1:0]  wdata,
	output logic          full,
	input  logic          pop,
	output logic [W-1:0]  rdata,
	output logic          empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [W-1:0]    mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] cnt_q;
	logic            do_push, do_pop;

	assign full    = (cnt_q == CNTW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/sbp_front.sv
// ----------------------------------------------------------------------------
// sbp_front: raster tracking and classification
// Keeps the source column/row counters, places and clips each pixel and
// decides transparency; emits one classified beat per accepted item.
// ----------------------------------------------------------------------------
module sbp_front import sbp_pkg::*; #(
	parameter int MAX_DIM    = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  item_t  item,
	input  logic   accept,
	output mid_t   entry
);

	localparam int CW    = $clog2(MAX_DIM);
	localparam int DIM_W = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
	localparam int DX_W  = DIM_W + 2;
	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);
	localparam logic [PIX_W-1:0] PIX_MASK = (PIXEL_BITS >= PIX_W) ? {PIX_W{1'b1}} :
		PIX_W'((32'd1 << PIXEL_BITS) - 32'd1);

	logic [CW-1:0]          col_q, row_q;
	logic [DIM_W-1:0]       sw, sh, dw, dh;
	logic [DIM_W-1:0]       col_p1, row_p1;
	logic                   last_col, last_row;
	logic signed [DX_W-1:0] dx, dy;
	logic                   in_bounds, opaque;
	logic [PIX_W-1:0]       pix;

	// zero acts as one, oversize acts as the maximum
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		logic [DIM_W-1:0] ve;
		ve = DIM_W'(v);
		if (ve == '0) begin
			return DIM_W'(1);
		end else if (ve > DIM_MAX) begin
			return DIM_MAX;
		end
		return ve;
	endfunction

	assign sw = clamp_dim(cfg.src_width);
	assign sh = clamp_dim(cfg.src_height);
	assign dw = clamp_dim(cfg.dest_width);
	assign dh = clamp_dim(cfg.dest_height);

	assign col_p1   = DIM_W'(col_q) + 1'b1;
	assign row_p1   = DIM_W'(row_q) + 1'b1;
	assign last_col = (col_p1 >= sw);
	assign last_row = (row_p1 >= sh);

	assign dx = DX_W'($signed(cfg.offset_x)) + $signed({2'b00, DIM_W'(col_q)});
	assign dy = DX_W'($signed(cfg.offset_y)) + $signed({2'b00, DIM_W'(row_q)});

	assign in_bounds = !dx[DX_W-1] && !dy[DX_W-1] &&
		(dx[DX_W-2:0] < {1'b0, dw}) && (dy[DX_W-2:0] < {1'b0, dh});

	assign pix    = item.pixel_value & PIX_MASK;
	assign opaque = (pix != KEY_ZERO) && (!cfg.use_palette || pix != KEY_FULL);

	always_comb begin
		entry        = '0;
		entry.pal_wr = (item.req_type == REQ_PAL_WR);
		entry.idx    = item.palette_index;
		if (item.req_type == REQ_PAL_WR) begin
			entry.value = item.pixel_value;   // palette stores the raw color
		end else begin
			entry.value = pix;
			entry.wr    = in_bounds && opaque;
			entry.lut   = cfg.use_palette;
			entry.col   = dx[COORD_W-1:0];
			entry.row   = dy[COORD_W-1:0];
			entry.done  = last_col && last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept && item.req_type == REQ_PIXEL) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_p1[CW-1:0];
			end else begin
				col_q <= col_p1[CW-1:0];
			end
		end
	end

endmodule

// File: rtl/core/sbp_back.sv
// ----------------------------------------------------------------------------
// sbp_back: palette and result formatting
// Applies palette writes in stream order and builds one result per beat.
// ----------------------------------------------------------------------------
module sbp_back import sbp_pkg::*; (
	input  logic     clk,
	input  mid_t     entry,
	input  logic     take,
	output result_t  result
);

	logic [PIX_W-1:0] pal_q [PAL_DEPTH];

	always_ff @(posedge clk) begin
		if (take && entry.pal_wr) begin
			pal_q[entry.idx] <= entry.value;
		end
	end

	// transparent, clipped and palette-write beats give write_valid low and a zero payload
	always_comb begin
		result             = '0;
		result.sprite_done = entry.done;
		if (entry.wr) begin
			result.write_valid = 1'b1;
			result.dest_col    = entry.col;
			result.dest_row    = entry.row;
			result.dest_value  = entry.lut ? pal_q[entry.value[PAL_IDX_W-1:0]] : entry.value;
		end
	end

endmodule

// File: rtl/core/sprite_blit_palette_transparency.sv
// ----------------------------------------------------------------------------
// sprite_blit_palette_transparency: sprite blitter with color key and palette
// Places raster-ordered sprite pixels at a signed offset, clips them to the
// destination, drops transparent ones and maps palette-mode values.
//
//   channel   handshake           payload    beat
//   input     push / full         item       pixel or palette write
//   result    empty / pop         result     one per input beat
//   config    cfg_we              cfg_index  cfg_data, no wait
//
// One beat per clock sustained while results are popped; an item's result
// reaches the result ports once the middle queue and then the result queue
// have registered it (front classification into a 2-entry queue, back lookup
// into a 2-entry result queue).
// Reset clears counters and queues and loads config defaults; palette entries are unset.
// Stalls on pop back up through the result queue, then the middle queue,
// before full rises; the two halves stall independently.
// ----------------------------------------------------------------------------
module sprite_blit_palette_transparency import sbp_pkg::*; #(
	parameter int MAX_DIM    = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input queue side
	input  logic                  push,
	output logic                  full,
	input  item_t                 item,
	// result queue side
	output logic                  empty,
	input  logic                  pop,
	output result_t               result,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	cfg_t    cfg_q;
	mid_t    mid_in, mid_out;
	logic    mid_full, mid_empty, mid_push, mid_pop;
	result_t back_res;
	logic    out_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_x    <= '0;
			cfg_q.offset_y    <= '0;
			cfg_q.src_width   <= CFG_W'(1);
			cfg_q.src_height  <= CFG_W'(1);
			cfg_q.dest_width  <= CFG_W'(1024);
			cfg_q.dest_height <= CFG_W'(1024);
			cfg_q.use_palette <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OFFSET_X:    cfg_q.offset_x    <= cfg_data;
				REG_OFFSET_Y:    cfg_q.offset_y    <= cfg_data;
				REG_SRC_WIDTH:   cfg_q.src_width   <= cfg_data;
				REG_SRC_HEIGHT:  cfg_q.src_height  <= cfg_data;
				REG_DEST_WIDTH:  cfg_q.dest_width  <= cfg_data;
				REG_DEST_HEIGHT: cfg_q.dest_height <= cfg_data;
				REG_USE_PALETTE: cfg_q.use_palette <= cfg_data[0];
				default: ;   // unmapped index: ignored
			endcase
		end
	end

	// front: counters, placement, clipping, color key
	assign full     = mid_full;
	assign mid_push = push && !mid_full;

	sbp_front #(
		.MAX_DIM    (MAX_DIM),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item),
		.accept (mid_push),
		.entry  (mid_in)
	);

	sbp_fifo #(
		.W     ($bits(mid_t)),
		.DEPTH (2)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_in),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_out),
		.empty  (mid_empty)
	);

	// back: palette, result formatting; moves when a result slot is free
	assign mid_pop = !mid_empty && !out_full;

	sbp_back u_back (
		.clk    (clk),
		.entry  (mid_out),
		.take   (mid_pop),
		.result (back_res)
	);

	sbp_fifo #(
		.W     ($bits(result_t)),
		.DEPTH (2)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_pop),
		.wdata  (back_res),
		.full   (out_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

	// checks
	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		mid_push |-> !mid_full)
		else $error("middle queue written while full");

	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !out_full)
		else $error("result queue written while full");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.write_valid) |->
			(result.dest_col == '0 && result.dest_row == '0 && result.dest_value == '0))
		else $error("result without write carries payload");

	a_pal_wr_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		(mid_pop && mid_out.pal_wr) |-> (!back_res.sprite_done && !back_res.write_valid))
		else $error("palette write produced a pixel result");

endmodule
